@@ design/fat16_root_dir_name_search_macros.svh @@
// ----------------------------------------------------------------------------
// FAT16 root directory name search: assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FAT16_ROOT_DIR_NAME_SEARCH_MACROS_SVH
`define FAT16_ROOT_DIR_NAME_SEARCH_MACROS_SVH

// same-cycle implication
`define FRDS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FRDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/frds_pkg.sv @@
// ----------------------------------------------------------------------------
// FAT16 root directory name search: package
// Entry layout offsets, directory byte codes, result types and the entry
// filter shared by the search logic.
// ----------------------------------------------------------------------------
package frds_pkg;

	localparam int ENTRY_BYTES = 32;
	localparam int OFF_W       = $clog2(ENTRY_BYTES);
	localparam int NAME_BYTES  = 8;
	localparam int NAME_W      = 8 * NAME_BYTES;
	localparam int CLUSTER_W   = 16;
	localparam int SIZE_W      = 32;

	typedef logic [OFF_W-1:0] offset_t;

	// byte positions inside a directory entry
	localparam offset_t OFF_FIRST   = OFF_W'(0);
	localparam offset_t OFF_ATTR    = OFF_W'(11);
	localparam offset_t OFF_CLUS_LO = OFF_W'(26);
	localparam offset_t OFF_CLUS_HI = OFF_W'(27);
	localparam offset_t OFF_SIZE_0  = OFF_W'(28);
	localparam offset_t OFF_SIZE_1  = OFF_W'(29);
	localparam offset_t OFF_SIZE_2  = OFF_W'(30);
	localparam offset_t OFF_LAST    = OFF_W'(31);

	// directory byte codes
	localparam logic [7:0] ATTR_LFN      = 8'h0F;
	localparam logic [7:0] ATTR_NONE     = 8'h00;
	localparam logic [7:0] ATTR_DIR      = 8'h10;
	localparam logic [7:0] ATTR_VOLUME   = 8'h08;
	localparam logic [7:0] NAME_DELETED  = 8'hE5;
	localparam logic [7:0] NAME_FREE     = 8'h00;
	localparam logic [7:0] NAME_KANJI_E5 = 8'h05;

	localparam logic STATUS_FOUND     = 1'b0;
	localparam logic STATUS_NOT_FOUND = 1'b1;

	typedef struct packed {
		logic                 status;
		logic [CLUSTER_W-1:0] start_cluster;
		logic [SIZE_W-1:0]    file_size;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t data;
	} result_req_t;

	// entry holds a plain file that may be matched by name
	function automatic logic is_candidate(input logic [7:0] first, input logic [7:0] attr);
		logic ok;
		ok = 1'b1;
		if (attr == ATTR_LFN || attr == ATTR_NONE)
			ok = 1'b0;
		if (first == NAME_DELETED || first == NAME_FREE || first == NAME_KANJI_E5)
			ok = 1'b0;
		if ((attr & (ATTR_DIR | ATTR_VOLUME)) != 8'h00)
			ok = 1'b0;
		return ok;
	endfunction

endpackage

@@ design/frds_ifs.sv @@
// ----------------------------------------------------------------------------
// FAT16 root directory name search: channel interfaces
// Valid/ready channels for the directory byte stream and the search result.
// ----------------------------------------------------------------------------
interface frds_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface frds_result_if;
	logic                           valid;
	logic                           ready;
	logic                           status;
	logic [frds_pkg::CLUSTER_W-1:0] start_cluster;
	logic [frds_pkg::SIZE_W-1:0]    file_size;

	modport source (output valid, output status, output start_cluster, output file_size,
		input ready);
	modport sink   (input valid, input status, input start_cluster, input file_size,
		output ready);
endinterface

@@ design/fat16_root_dir_name_search.sv @@
// ----------------------------------------------------------------------------
// FAT16 root directory name search: top level
// Scans directory bytes for a configured 8-byte name and reports the start
// cluster and file size of the first matching file, or not-found.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, and the result it
// causes is held in the result register.
// Throughput: one byte per cycle; the per-byte compare and capture sit
// between those two registers, and a held result stalls input only when full.
// Reset: arst_n clears the entry state, both valid flags and target_name.
module fat16_root_dir_name_search (
	input  logic                        clk,
	input  logic                        arst_n,
	frds_byte_if.sink                   stream,
	frds_result_if.source               result,
	input  logic                        wr_en,
	input  logic [frds_pkg::NAME_W-1:0] wr_data
);

	logic [frds_pkg::NAME_W-1:0] target_name_q;

	logic       s1_valid_q;
	logic [7:0] data_s1;
	logic       last_s1;

	logic                  out_valid_q;
	frds_pkg::result_t     out_data_q;
	frds_pkg::result_req_t res;

	logic out_free;
	logic step;

	assign out_free     = ~out_valid_q | result.ready;
	assign step         = s1_valid_q & out_free;
	assign stream.ready = ~s1_valid_q | out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			target_name_q <= '0;
		else if (wr_en)
			target_name_q <= wr_data;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (stream.ready)
			s1_valid_q <= stream.valid;
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			data_s1 <= stream.data_byte;
			last_s1 <= stream.last_byte;
		end
	end

	frds_entry_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.data_byte   (data_s1),
		.last_byte   (last_s1),
		.target_name (target_name_q),
		.res         (res)
	);

	// result register: hold while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= res.valid;
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid)
			out_data_q <= res.data;
	end

	assign result.valid         = out_valid_q;
	assign result.status        = out_data_q.status;
	assign result.start_cluster = out_data_q.start_cluster;
	assign result.file_size     = out_data_q.file_size;

endmodule

@@ design/frds_entry_core.sv @@
// ----------------------------------------------------------------------------
// FAT16 root directory name search: entry tracker
// Walks the 32-byte entries, compares names, captures cluster and size and
// decides the result for the byte presented on each step.
// ----------------------------------------------------------------------------
module frds_entry_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [7:0]                  data_byte,
	input  logic                        last_byte,
	input  logic [frds_pkg::NAME_W-1:0] target_name,
	output frds_pkg::result_req_t       res
);

	frds_pkg::offset_t              entry_offset_q;
	logic                           name_equal_q;
	logic [7:0]                     first_name_byte_q;
	logic [7:0]                     attribute_byte_q;
	logic [frds_pkg::CLUSTER_W-1:0] cluster_accum_q;
	logic [frds_pkg::SIZE_W-1:0]    size_accum_q;
	logic                           match_done_q;

	logic       in_name;
	logic [7:0] want;
	logic       name_eq_now;
	logic       entry_end;
	logic       found;
	logic       not_found;

	always_comb begin
		in_name     = entry_offset_q < frds_pkg::OFF_W'(frds_pkg::NAME_BYTES);
		want        = target_name[{entry_offset_q[2:0], 3'b000} +: 8];
		name_eq_now = name_equal_q & ~(in_name & (data_byte != want));
		entry_end   = entry_offset_q == frds_pkg::OFF_LAST;
		found       = ~match_done_q & entry_end & name_equal_q &
			frds_pkg::is_candidate(first_name_byte_q, attribute_byte_q);
		not_found   = last_byte & ~match_done_q & ~found;

		res.valid = step & (found | not_found);
		if (found) begin
			res.data.status        = frds_pkg::STATUS_FOUND;
			res.data.start_cluster = cluster_accum_q;
			res.data.file_size     = {data_byte, size_accum_q[23:0]};
		end else begin
			res.data.status        = frds_pkg::STATUS_NOT_FOUND;
			res.data.start_cluster = '0;
			res.data.file_size     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_offset_q    <= '0;
			name_equal_q      <= 1'b1;
			first_name_byte_q <= '0;
			attribute_byte_q  <= '0;
			cluster_accum_q   <= '0;
			size_accum_q      <= '0;
			match_done_q      <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				// end of region: start a fresh search
				entry_offset_q    <= '0;
				name_equal_q      <= 1'b1;
				first_name_byte_q <= '0;
				attribute_byte_q  <= '0;
				cluster_accum_q   <= '0;
				size_accum_q      <= '0;
				match_done_q      <= 1'b0;
			end else if (!match_done_q) begin
				case (entry_offset_q)
					frds_pkg::OFF_FIRST:   first_name_byte_q      <= data_byte;
					frds_pkg::OFF_ATTR:    attribute_byte_q       <= data_byte;
					frds_pkg::OFF_CLUS_LO: cluster_accum_q[7:0]   <= data_byte;
					frds_pkg::OFF_CLUS_HI: cluster_accum_q[15:8]  <= data_byte;
					frds_pkg::OFF_SIZE_0:  size_accum_q[7:0]      <= data_byte;
					frds_pkg::OFF_SIZE_1:  size_accum_q[15:8]     <= data_byte;
					frds_pkg::OFF_SIZE_2:  size_accum_q[23:16]    <= data_byte;
					default: ;
				endcase
				if (found)
					match_done_q <= 1'b1;
				if (entry_end) begin
					entry_offset_q <= '0;
					name_equal_q   <= 1'b1;
				end else begin
					entry_offset_q <= entry_offset_q + 1'b1;
					name_equal_q   <= name_eq_now;
				end
			end
		end
	end

endmodule

@@ design/frds_checker.sv @@
// ----------------------------------------------------------------------------
// FAT16 root directory name search: port checker
// Watches the top level ports for result timing and payload rules.
// ----------------------------------------------------------------------------
`include "fat16_root_dir_name_search_macros.svh"

module frds_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           stream_valid,
	input logic                           stream_ready,
	input logic                           result_valid,
	input logic                           result_ready,
	input logic                           result_status,
	input logic [frds_pkg::CLUSTER_W-1:0] result_start_cluster,
	input logic [frds_pkg::SIZE_W-1:0]    result_file_size
);

	`FRDS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_status) && $stable(result_start_cluster) && $stable(result_file_size), "result item changed while stalled")

	`FRDS_ASSERT_NOW(a_not_found_zero, result_valid && result_status == frds_pkg::STATUS_NOT_FOUND, result_start_cluster == '0 && result_file_size == '0, "not-found item carries nonzero fields")

	`FRDS_ASSERT_NOW(a_stall_only_when_full, !stream_ready, result_valid && !result_ready, "input stalled while result side can move")

	`FRDS_ASSERT_NOW(a_result_follows_input, $rose(result_valid), $past(stream_valid && stream_ready, 2), "result item without a byte accepted two cycles earlier")

endmodule

bind fat16_root_dir_name_search frds_checker u_frds_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.stream_valid         (stream.valid),
	.stream_ready         (stream.ready),
	.result_valid         (result.valid),
	.result_ready         (result.ready),
	.result_status        (result.status),
	.result_start_cluster (result.start_cluster),
	.result_file_size     (result.file_size)
);
